@@ sv/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescape block.
// No dependencies; used by the decoder and the top level.
package jsu_pkg;

    // Decoder modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BODY = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    // Byte counter operations
    localparam logic [1:0] CNT_HOLD  = 2'd0;
    localparam logic [1:0] CNT_CLEAR = 2'd1;
    localparam logic [1:0] CNT_ONE   = 2'd2;
    localparam logic [1:0] CNT_INC   = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    // Number of hex digits skipped after \u
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // Decoder step: next state plus the result it produces
    typedef struct packed {
        logic [1:0] mode_next;
        logic [2:0] hex_next;
        logic [1:0] cnt_op;
        logic       has_result;
        logic [7:0] out_char;
        logic       is_end;
        logic       bad_start;
    } jsu_step_t;

    // Escape letter to character
    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_B:    r = 8'h08;
            CH_F:    r = 8'h0C;
            CH_N:    r = 8'h0A;
            CH_R:    r = 8'h0D;
            CH_T:    r = 8'h09;
            default: r = c;   // quote, backslash, slash and unknown pass as is
        endcase
        return r;
    endfunction

endpackage

@@ sv/jsu_decode.sv @@
// Combinational step of the unescape mode machine: one byte in, next state out.
// Depends on jsu_pkg for mode codes, counter ops and the step struct.
module jsu_decode (
    input  logic [1:0]         mode,
    input  logic [2:0]         hex_left,
    input  logic [7:0]         in_byte,
    input  logic               begin_req,
    output jsu_pkg::jsu_step_t step
);

    logic [2:0] hex_dec;

    assign hex_dec = (hex_left != 3'd0) ? hex_left - 3'd1 : 3'd0;

    always_comb begin
        step            = '0;
        step.mode_next  = mode;
        step.hex_next   = hex_left;
        step.cnt_op     = jsu_pkg::CNT_HOLD;

        if (begin_req) begin
            // New string: must open with a quote
            step.hex_next = 3'd0;
            if (in_byte != jsu_pkg::CH_QUOTE) begin
                step.mode_next  = jsu_pkg::MODE_IDLE;
                step.cnt_op     = jsu_pkg::CNT_CLEAR;
                step.has_result = 1'b1;
                step.bad_start  = 1'b1;
            end else begin
                step.mode_next = jsu_pkg::MODE_BODY;
                step.cnt_op    = jsu_pkg::CNT_ONE;
            end
        end else begin
            case (mode)
                jsu_pkg::MODE_BODY: begin
                    step.cnt_op = jsu_pkg::CNT_INC;
                    if (in_byte == jsu_pkg::CH_QUOTE) begin
                        step.mode_next  = jsu_pkg::MODE_IDLE;
                        step.has_result = 1'b1;
                        step.is_end     = 1'b1;
                    end else if (in_byte == jsu_pkg::CH_BSLASH) begin
                        step.mode_next = jsu_pkg::MODE_ESC;
                    end else begin
                        step.has_result = 1'b1;
                        step.out_char   = in_byte;
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    step.cnt_op     = jsu_pkg::CNT_INC;
                    step.has_result = 1'b1;
                    if (in_byte == jsu_pkg::CH_U) begin
                        step.mode_next = jsu_pkg::MODE_HEX;
                        step.hex_next  = jsu_pkg::HEX_DIGITS;
                        step.out_char  = jsu_pkg::CH_QMARK;
                    end else begin
                        step.mode_next = jsu_pkg::MODE_BODY;
                        step.out_char  = jsu_pkg::map_escape(in_byte);
                    end
                end
                jsu_pkg::MODE_HEX: begin
                    // Skip hex digits blindly
                    step.cnt_op   = jsu_pkg::CNT_INC;
                    step.hex_next = hex_dec;
                    if (hex_dec == 3'd0) begin
                        step.mode_next = jsu_pkg::MODE_BODY;
                    end
                end
                default: begin
                    // Idle without begin: byte ignored
                end
            endcase
        end
    end

endmodule

@@ sv/json_string_unescape.sv @@
// Top level of the streaming JSON string unescape block.
// Depends on jsu_pkg and jsu_decode.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one raw byte per request plus
//   s_begin_req, which marks the opening byte of a new string. Result
//   channel (m_valid/m_ready) carries decoded characters, one end result
//   with the consumed length (both quotes, saturating), or an error result
//   when the opening byte is not a double quote. Escape prefixes, skipped
//   hex digits and idle bytes produce no result.
// Path: the accept edge loads the input register, then the decode step
//   is loaded into the result register, where it waits until taken.
// Throughput: one byte per cycle sustained while m_ready stays high; the
//   mode machine update is a single step of the decoder between the two registers.
// Reset: aresetn low clears both pipeline stages and returns the decoder
//   to idle with a zero byte count.
// Stall: while a result waits and m_ready is low the result register holds;
//   the input register still takes one byte, then s_ready drops until the result
//   is taken.
module json_string_unescape #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_in_byte,
    input  logic                   s_begin_req,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_char,
    output logic                   m_is_end,
    output logic                   m_bad_start,
    output logic [COUNT_WIDTH-1:0] m_consumed_length
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_begin_reg;
    logic [1:0]             mode_reg;
    logic [2:0]             hex_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   out_valid_reg;
    logic [7:0]             out_char_reg;
    logic                   out_end_reg;
    logic                   out_bad_reg;
    logic [COUNT_WIDTH-1:0] out_len_reg;
    logic                   fire;
    jsu_pkg::jsu_step_t     step;

    // Decode stage moves when the result register is free or being drained
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    jsu_decode u_decode (
        .mode      (mode_reg),
        .hex_left  (hex_reg),
        .in_byte   (in_byte_reg),
        .begin_req (in_begin_reg),
        .step      (step)
    );

    // Saturating byte counter
    always_comb begin
        case (step.cnt_op)
            jsu_pkg::CNT_CLEAR: count_next = '0;
            jsu_pkg::CNT_ONE:   count_next = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            jsu_pkg::CNT_INC:   count_next = (count_reg != COUNT_MAX) ?
                                             count_reg + 1'b1 : count_reg;
            default:            count_next = count_reg;
        endcase
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_in_byte;
            in_begin_reg <= s_begin_req;
        end
    end

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= jsu_pkg::MODE_IDLE;
            hex_reg   <= 3'd0;
            count_reg <= '0;
        end else if (fire) begin
            mode_reg  <= step.mode_next;
            hex_reg   <= step.hex_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= step.has_result;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire) begin
            out_char_reg <= step.out_char;
            out_end_reg  <= step.is_end;
            out_bad_reg  <= step.bad_start;
            out_len_reg  <= step.is_end ? count_next : '0;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_out_char        = out_char_reg;
    assign m_is_end          = out_end_reg;
    assign m_bad_start       = out_bad_reg;
    assign m_consumed_length = out_len_reg;

endmodule

@@ sv/jsu_checker.sv @@
// Port-level checks for json_string_unescape, attached by bind.
// Depends only on the top level's ports.
module jsu_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [7:0]             m_out_char,
    input logic                   m_is_end,
    input logic                   m_bad_start,
    input logic [COUNT_WIDTH-1:0] m_consumed_length
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_is_end)
            && $stable(m_bad_start) && $stable(m_consumed_length))
        else $error("result changed while stalled");

    // Error result carries nothing else
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_start |-> !m_is_end && m_out_char == 8'd0
            && m_consumed_length == '0)
        else $error("error result with payload");

    // End result: no character, at least both quotes counted
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_end |-> m_out_char == 8'd0 && m_consumed_length >= 2)
        else $error("bad end result");

    // Length only on end results
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_end |-> m_consumed_length == '0)
        else $error("length on non-end result");

    // A result cannot appear without an earlier input request
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2) || $past(!s_ready, 1))
        else $error("result without request");

endmodule

bind json_string_unescape jsu_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_jsu_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_out_char        (m_out_char),
    .m_is_end          (m_is_end),
    .m_bad_start       (m_bad_start),
    .m_consumed_length (m_consumed_length)
);
